// ===== rtl/core/gpm_pkg.sv =====
// ---------------------------------------------------------------------------
// gpm_pkg: shared definitions for the gyro pointer motion unit
//
// Fixed-point formats, configuration reset values, register indexes and the
// command and status words that pass between the controller and datapath.
// ---------------------------------------------------------------------------
package gpm_pkg;

  // Fraction bits of the smoothed values and accumulators.
  localparam int FRAC_BITS = 16;

  // Fraction bits of the sensitivity and smoothing weights (Q0.16).
  localparam int WEIGHT_BITS = 16;

  // Field widths.
  localparam int RATE_W     = 16;
  localparam int AXIS_W     = RATE_W + 1;
  localparam int MOVE_W     = 8;
  localparam int STATE_W    = 32;
  localparam int DEAD_W     = 15;
  localparam int WEIGHT_W   = WEIGHT_BITS;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Shared multiplier operands and product.
  localparam int MUL_A_W = STATE_W;
  localparam int MUL_B_W = WEIGHT_W + 2;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Rate times sensitivity, and its rescaling to FRAC_BITS.
  localparam int PROD_T_W = AXIS_W + WEIGHT_W;
  localparam int SCALE_UP = (FRAC_BITS >= WEIGHT_BITS) ? FRAC_BITS - WEIGHT_BITS : 0;
  localparam int SCALE_DN = (FRAC_BITS < WEIGHT_BITS) ? WEIGHT_BITS - FRAC_BITS : 0;
  localparam int SCALED_W = PROD_T_W + SCALE_UP;

  // Whole-pixel part of an accumulator.
  localparam int WHOLE_W = STATE_W - FRAC_BITS;

  // Configuration reset values.
  localparam logic [DEAD_W-1:0]   DEAD_BAND_RST   = DEAD_W'(16);
  localparam logic [WEIGHT_W-1:0] SENS_RST        = WEIGHT_W'(4588);
  localparam logic [WEIGHT_W-1:0] SMOOTHING_RST   = WEIGHT_W'(26214);

  // Largest emitted step.
  localparam int MOVE_LIMIT = 127;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEAD_BAND   = 2'd0,
    REG_SENSITIVITY = 2'd1,
    REG_SMOOTHING   = 2'd2
  } cfg_idx_t;

  // Axis select: the vertical axis is worked first.
  typedef enum logic {
    AXIS_Y = 1'b0,
    AXIS_X = 1'b1
  } axis_t;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_NONE  = 4'd0,
    OP_LOAD  = 4'd1,
    OP_MUL_T = 4'd2,
    OP_TGT   = 4'd3,
    OP_MUL_A = 4'd4,
    OP_MUL_B = 4'd5,
    OP_FILT  = 4'd6,
    OP_UPD   = 4'd7,
    OP_EMIT  = 4'd8
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    axis_t  sel;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/core/gpm_if.sv =====
// ---------------------------------------------------------------------------
// gpm_if: channel interfaces of the gyro pointer motion unit
//
// Sample input, move output and configuration write channels, each a
// valid/ready handshake with its payload.
// ---------------------------------------------------------------------------
interface gpm_in_if import gpm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [RATE_W-1:0] gyro_x_rate;
  logic signed [RATE_W-1:0] gyro_z_rate;

  modport source (output valid, output gyro_x_rate, output gyro_z_rate, input ready);
  modport sink   (input valid, input gyro_x_rate, input gyro_z_rate, output ready);
endinterface

interface gpm_out_if import gpm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [MOVE_W-1:0] move_x;
  logic signed [MOVE_W-1:0] move_y;

  modport source (output valid, output move_x, output move_y, input ready);
  modport sink   (input valid, input move_x, input move_y, output ready);
endinterface

interface gpm_cfg_if import gpm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/gpm_ctrl.sv =====
// ---------------------------------------------------------------------------
// gpm_ctrl: sequencer of the gyro pointer motion unit
//
// Steps the datapath through the three shared-multiplier products and the
// filter and accumulator update of each axis, then the move emission.
// ---------------------------------------------------------------------------
module gpm_ctrl import gpm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_MUL_T = 8'b0000_0010,
    ST_TGT   = 8'b0000_0100,
    ST_MUL_A = 8'b0000_1000,
    ST_MUL_B = 8'b0001_0000,
    ST_FILT  = 8'b0010_0000,
    ST_UPD   = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  axis_t  axis, axis_next;

  // A new word is taken only between items, and never while in reset.
  assign in_ready = (state == ST_IDLE) && !rst;

  // Next state and the command for the current step.
  always_comb begin
    state_next = state;
    axis_next  = axis;
    cmd.op     = OP_NONE;
    cmd.sel    = axis;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.op     = OP_LOAD;
          axis_next  = AXIS_Y;
          state_next = ST_MUL_T;
        end
      end
      ST_MUL_T: begin
        cmd.op     = OP_MUL_T;
        state_next = ST_TGT;
      end
      ST_TGT: begin
        cmd.op     = OP_TGT;
        state_next = ST_MUL_A;
      end
      ST_MUL_A: begin
        cmd.op     = OP_MUL_A;
        state_next = ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd.op     = OP_MUL_B;
        state_next = ST_FILT;
      end
      ST_FILT: begin
        cmd.op     = OP_FILT;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        cmd.op = OP_UPD;
        if (axis == AXIS_Y) begin
          axis_next  = AXIS_X;
          state_next = ST_MUL_T;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Hold here while the previous move still waits at the output.
        if (stat.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      axis  <= AXIS_Y;
    end else begin
      state <= state_next;
      axis  <= axis_next;
    end
  end

endmodule

// ===== rtl/core/gpm_datapath.sv =====
// ---------------------------------------------------------------------------
// gpm_datapath: arithmetic and state of the gyro pointer motion unit
//
// Holds the configuration, the per-axis smoothed values and accumulators,
// one shared signed multiplier and the output register.
// ---------------------------------------------------------------------------
module gpm_datapath import gpm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  dp_cmd_t    cmd,
  output dp_stat_t   stat,
  gpm_in_if.sink     sample,
  gpm_out_if.source  move,
  gpm_cfg_if.sink    cfg
);

  localparam logic signed [SCALED_W:0] DN_BIAS =
    (SCALED_W + 1)'((64'd1 << SCALE_DN) - 64'd1);
  localparam logic signed [PROD_W:0] WEIGHT_BIAS =
    (PROD_W + 1)'((64'd1 << WEIGHT_BITS) - 64'd1);
  localparam logic signed [STATE_W:0] FRAC_BIAS =
    (STATE_W + 1)'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic [MUL_B_W-1:0] WEIGHT_ONE = MUL_B_W'(64'd1 << WEIGHT_BITS);
  localparam logic signed [WHOLE_W-1:0] WHOLE_HI = WHOLE_W'(MOVE_LIMIT);
  localparam logic signed [WHOLE_W-1:0] WHOLE_LO = -WHOLE_W'(MOVE_LIMIT);

  // Saturates a sign-extended value to the signed 32-bit range.
  function automatic logic signed [STATE_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -64'sh0000_0000_8000_0000;
    if (v > hi) begin
      sat32 = hi[STATE_W-1:0];
    end else if (v < lo) begin
      sat32 = lo[STATE_W-1:0];
    end else begin
      sat32 = v[STATE_W-1:0];
    end
  endfunction

  // Saturates a whole-pixel count to the emitted step range.
  function automatic logic signed [MOVE_W-1:0] sat_move(input logic signed [WHOLE_W-1:0] w);
    if (w > WHOLE_HI) begin
      sat_move = MOVE_W'(MOVE_LIMIT);
    end else if (w < WHOLE_LO) begin
      sat_move = -MOVE_W'(MOVE_LIMIT);
    end else begin
      sat_move = w[MOVE_W-1:0];
    end
  endfunction

  // Configuration registers.
  logic [DEAD_W-1:0]   dead_band;
  logic [WEIGHT_W-1:0] sensitivity;
  logic [WEIGHT_W-1:0] smoothing;

  // Per-axis state, indexed by axis_t.
  logic signed [AXIS_W-1:0]  rate   [2];
  logic signed [STATE_W-1:0] smooth [2];
  logic signed [STATE_W-1:0] accum  [2];

  // Working registers.
  logic signed [STATE_W-1:0] target;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  part;
  logic signed [STATE_W-1:0] sm;

  // Output register.
  logic                     out_valid;
  logic signed [MOVE_W-1:0] out_x;
  logic signed [MOVE_W-1:0] out_y;

  // Combinational signals.
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   mul_p;
  logic signed [AXIS_W-1:0]   rate_sel;
  logic signed [PROD_T_W-1:0] prod_t;
  logic signed [SCALED_W:0]   scaled;
  logic signed [SCALED_W:0]   scaled_q;
  logic signed [PROD_W:0]     fsum;
  logic signed [PROD_W:0]     fsum_q;
  logic [AXIS_W-1:0]          mag;
  logic                       in_dead;
  logic signed [STATE_W:0]    asum;
  logic signed [STATE_W:0]    ab_y;
  logic signed [STATE_W:0]    ab_x;
  logic signed [STATE_W:0]    aq_y;
  logic signed [STATE_W:0]    aq_x;
  logic signed [WHOLE_W-1:0]  whole_y;
  logic signed [WHOLE_W-1:0]  whole_x;

  assign cfg.ready     = !rst;
  assign move.valid    = out_valid;
  assign move.move_x   = out_x;
  assign move.move_y   = out_y;
  assign stat.out_free = !out_valid || move.ready;

  // Shared multiplier operand selection.
  always_comb begin
    rate_sel = rate[cmd.sel];
    mul_a    = '0;
    mul_b    = '0;
    case (cmd.op)
      OP_MUL_T: begin
        mul_a = MUL_A_W'(rate_sel);
        mul_b = MUL_B_W'(sensitivity);
      end
      OP_MUL_A: begin
        mul_a = target;
        mul_b = WEIGHT_ONE - MUL_B_W'(smoothing);
      end
      OP_MUL_B: begin
        mul_a = smooth[cmd.sel];
        mul_b = MUL_B_W'(smoothing);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Rescaling of rate times sensitivity to the accumulator format.
  always_comb begin
    prod_t   = prod[PROD_T_W-1:0];
    scaled   = (SCALED_W + 1)'(prod_t) <<< SCALE_UP;
    scaled_q = (scaled + (scaled < 0 ? DN_BIAS : '0)) >>> SCALE_DN;
  end

  // Filter sum, divided by the weight scale toward zero.
  always_comb begin
    fsum   = (PROD_W + 1)'(part) + (PROD_W + 1)'(prod);
    fsum_q = (fsum + (fsum < 0 ? WEIGHT_BIAS : '0)) >>> WEIGHT_BITS;
  end

  // Deadzone test and accumulator sum of the selected axis.
  always_comb begin
    mag     = (rate_sel < 0) ? AXIS_W'(-rate_sel) : AXIS_W'(rate_sel);
    in_dead = (mag <= AXIS_W'(dead_band));
    asum    = (STATE_W + 1)'(accum[cmd.sel]) + (STATE_W + 1)'(sm);
  end

  // Whole-pixel parts, truncated toward zero.
  always_comb begin
    ab_y    = (STATE_W + 1)'(accum[AXIS_Y]);
    ab_x    = (STATE_W + 1)'(accum[AXIS_X]);
    aq_y    = (ab_y + (ab_y < 0 ? FRAC_BIAS : '0)) >>> FRAC_BITS;
    aq_x    = (ab_x + (ab_x < 0 ? FRAC_BIAS : '0)) >>> FRAC_BITS;
    whole_y = aq_y[WHOLE_W-1:0];
    whole_x = aq_x[WHOLE_W-1:0];
  end

  // Configuration writes; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      dead_band   <= DEAD_BAND_RST;
      sensitivity <= SENS_RST;
      smoothing   <= SMOOTHING_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_DEAD_BAND:   dead_band   <= cfg.data[DEAD_W-1:0];
        REG_SENSITIVITY: sensitivity <= cfg.data[WEIGHT_W-1:0];
        REG_SMOOTHING:   smoothing   <= cfg.data[WEIGHT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Working registers; they need no reset.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        rate[AXIS_X] <= -AXIS_W'(sample.gyro_x_rate);
        rate[AXIS_Y] <= AXIS_W'(sample.gyro_z_rate);
      end
      OP_MUL_T: prod <= mul_p;
      OP_TGT:   target <= sat32(64'(scaled_q));
      OP_MUL_A: prod <= mul_p;
      OP_MUL_B: begin
        part <= prod;
        prod <= mul_p;
      end
      OP_FILT:  sm <= fsum_q[STATE_W-1:0];
      default: begin
      end
    endcase
  end

  // Smoothed values and accumulators.
  always_ff @(posedge clk) begin
    if (rst) begin
      smooth[AXIS_Y] <= '0;
      smooth[AXIS_X] <= '0;
      accum[AXIS_Y]  <= '0;
      accum[AXIS_X]  <= '0;
    end else if (cmd.op == OP_UPD) begin
      if (in_dead) begin
        smooth[cmd.sel] <= '0;
        accum[cmd.sel]  <= '0;
      end else if (target != '0) begin
        smooth[cmd.sel] <= sm;
        accum[cmd.sel]  <= sat32(64'(asum));
      end
    end else if (cmd.op == OP_EMIT) begin
      // Removing a zero whole part leaves the accumulator as it is.
      accum[AXIS_Y] <= accum[AXIS_Y] - {whole_y, {FRAC_BITS{1'b0}}};
      accum[AXIS_X] <= accum[AXIS_X] - {whole_x, {FRAC_BITS{1'b0}}};
    end
  end

  // Output valid flag: set only when a whole pixel has built up.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_EMIT && (whole_x != '0 || whole_y != '0)) begin
      out_valid <= 1'b1;
    end else if (move.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      out_x <= sat_move(whole_x);
      out_y <= sat_move(whole_y);
    end
  end

endmodule

// ===== rtl/core/gyro_pointer_motion_unit.sv =====
// ---------------------------------------------------------------------------
// gyro_pointer_motion_unit: gyro rates to relative pointer moves
//
//   channel  dir  handshake           payload
//   sample   in   valid/ready         gyro_x_rate, gyro_z_rate (s16 each)
//   move     out  valid/ready         move_x, move_y (s8 each, +-127)
//   cfg      in   valid/ready (ready) index (2 bits), data (16 bits)
//
// An item takes one step to take the word, six steps per axis around the
// single shared 32x18 multiplier (three products each) and one to emit.
// The move lands in the output register at the emit step, and the next
// word can be taken once that step is done.
// Reset (rst, synchronous) restores the register defaults and clears the
// smoothed values and accumulators. A move waiting at the output does not
// stop the next word being taken; it stalls only the emit step behind it.
// ---------------------------------------------------------------------------
module gyro_pointer_motion_unit import gpm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  gpm_in_if.sink    sample,
  gpm_out_if.source move,
  gpm_cfg_if.sink   cfg
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  // The sequencer decides when a sample word is taken.
  assign sample.ready = in_ready;

  // Sequencer.
  gpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Arithmetic, state and output register.
  gpm_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .stat   (stat),
    .sample (sample),
    .move   (move),
    .cfg    (cfg)
  );

endmodule

// ===== dv/gpm_motion_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// gpm_motion_checker: move predictor and scoreboard for the pointer unit
//
// Watches the sample, move and configuration channels beside the block. Each
// accepted sample word is run through an independent model of the deadzone,
// gain, smoothing filter and sub-pixel accumulators. Any move it should cause
// is queued, and every move word the block emits is compared field by field
// with the oldest queued move.
// ---------------------------------------------------------------------------
module gpm_motion_checker import gpm_pkg::*; (
  input  logic clk,
  input  logic rst,
  gpm_in_if    sample,
  gpm_out_if   move,
  gpm_cfg_if   cfg,
  output int   errors,
  output int   moves_owed
);

  localparam longint ONE_PX    = longint'(1) << FRAC_BITS;
  localparam longint UNITY_WT  = longint'(1) << WEIGHT_BITS;
  localparam longint S32_MAX   = 64'sd2147483647;
  localparam longint S32_MIN   = -64'sd2147483648;
  localparam int     MAX_LINES = 40;

  typedef struct packed {
    logic signed [MOVE_W-1:0] dx;
    logic signed [MOVE_W-1:0] dy;
  } move_word_t;

  // Local copy of the register file and the per-axis filter state.
  logic [DEAD_W-1:0]         dead_band_q;
  logic [WEIGHT_W-1:0]       gain_q;
  logic [WEIGHT_W-1:0]       keep_q;
  logic signed [STATE_W-1:0] smooth_q [2];
  logic signed [STATE_W-1:0] accum_q [2];

  move_word_t moves_due [$];
  move_word_t due;
  longint     whole_x;
  longint     whole_y;
  int         fail_count = 0;
  int         owed_count = 0;

  assign errors     = fail_count;
  assign moves_owed = owed_count;

  function automatic longint clamp32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  function automatic logic signed [MOVE_W-1:0] clamp_move(longint v);
    if (v > MOVE_LIMIT) return MOVE_W'(MOVE_LIMIT);
    if (v < -MOVE_LIMIT) return MOVE_W'(-MOVE_LIMIT);
    return MOVE_W'(v);
  endfunction

  // Runs one axis for one sample and returns the whole pixels now held in
  // its accumulator. A rate inside the deadzone clears the axis; a target
  // that scales to exactly zero leaves the filter and accumulator alone.
  function automatic longint advance_axis(axis_t ax, longint rate);
    longint mag;
    longint scaled;
    longint target;
    longint filt;
    mag = (rate < 0) ? -rate : rate;
    if (mag <= longint'(dead_band_q)) begin
      smooth_q[ax] = '0;
      accum_q[ax]  = '0;
      return 0;
    end
    scaled = (rate * longint'(gain_q) * (longint'(1) << SCALE_UP)) /
             (longint'(1) << SCALE_DN);
    target = clamp32(scaled);
    if (target != 0) begin
      filt = (target * (UNITY_WT - longint'(keep_q)) +
              longint'(smooth_q[ax]) * longint'(keep_q)) / UNITY_WT;
      smooth_q[ax] = STATE_W'(clamp32(filt));
      accum_q[ax]  = STATE_W'(clamp32(longint'(accum_q[ax]) + longint'(smooth_q[ax])));
    end
    return longint'(accum_q[ax]) / ONE_PX;
  endfunction

  task automatic report_mismatch(string what, longint seen, longint owed);
    fail_count++;
    if (fail_count <= MAX_LINES) begin
      $display("%0t move check: %s got %0d, expected %0d", $time, what, seen, owed);
    end
  endtask

  // All three channels are sampled at the clock edge on which words move.
  always @(posedge clk) begin
    if (rst) begin
      dead_band_q = DEAD_BAND_RST;
      gain_q      = SENS_RST;
      keep_q      = SMOOTHING_RST;
      smooth_q[AXIS_X] = '0;
      smooth_q[AXIS_Y] = '0;
      accum_q[AXIS_X]  = '0;
      accum_q[AXIS_Y]  = '0;
      moves_due.delete();
    end else begin
      // Emitted moves are checked first: a move can never belong to the
      // sample word taken on the same edge.
      if (move.valid && move.ready) begin
        if (moves_due.size() == 0) begin
          report_mismatch("move with none due, move_x", move.move_x, 0);
        end else begin
          due = moves_due.pop_front();
          if (move.move_x !== due.dx) report_mismatch("move_x", move.move_x, due.dx);
          if (move.move_y !== due.dy) report_mismatch("move_y", move.move_y, due.dy);
        end
      end

      // Register writes; values are cut to the register width and an
      // unused index is dropped.
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_DEAD_BAND:   dead_band_q = cfg.data[DEAD_W-1:0];
          REG_SENSITIVITY: gain_q      = cfg.data[WEIGHT_W-1:0];
          REG_SMOOTHING:   keep_q      = cfg.data[WEIGHT_W-1:0];
          default: ;
        endcase
      end

      // The vertical axis is the Z rate, the horizontal one the negated X
      // rate. Whole pixels leave the accumulators even when the step is cut
      // to the move limit.
      if (sample.valid && sample.ready) begin
        whole_y = advance_axis(AXIS_Y, longint'(sample.gyro_z_rate));
        whole_x = advance_axis(AXIS_X, -longint'(sample.gyro_x_rate));
        if (whole_x != 0 || whole_y != 0) begin
          accum_q[AXIS_X] = STATE_W'(longint'(accum_q[AXIS_X]) - whole_x * ONE_PX);
          accum_q[AXIS_Y] = STATE_W'(longint'(accum_q[AXIS_Y]) - whole_y * ONE_PX);
          moves_due.push_back('{dx: clamp_move(whole_x), dy: clamp_move(whole_y)});
        end
      end
    end
    owed_count = moves_due.size();
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: regression bench for the gyro pointer motion unit
//
// Drives sample and configuration words into the block and drains its move
// words, while a checker beside it predicts every move. A short directed run
// covers the rate and register extremes, the deadzone edge, zero gain and
// saturating moves; random phases under varied settings follow, mostly held
// rotations with jitter so the accumulators build up. The sender works in
// bursts and the move sink stalls on a pattern of its own, including one long
// hold-off that backs the block up onto its input.
// ---------------------------------------------------------------------------
module tb_top;
  import gpm_pkg::*;

  localparam int     CLK_PERIOD    = 12;
  localparam int     RESET_CYCLES  = 11;
  localparam int     SETTLE_CYCLES = 40;
  localparam int     PHASES        = 5;
  localparam int     PHASE_ITEMS   = 100;
  localparam int     HOLD_AT       = 1500;
  localparam int     HOLD_LONG     = 400;
  localparam longint LIMIT_NS      = longint'(800_000) * CLK_PERIOD;

  localparam logic [CFG_IDX_W-1:0]     CFG_IDX_UNUSED = 2'd3;
  localparam logic signed [RATE_W-1:0] RATE_MAX       = 16'sh7FFF;
  localparam logic signed [RATE_W-1:0] RATE_MIN       = 16'sh8000;

  logic clk;
  logic rst;
  int   errors;
  int   moves_owed;
  int   burst_left;
  int   db_now;

  gpm_in_if  sample_ch ();
  gpm_out_if move_ch ();
  gpm_cfg_if cfg_ch ();

  gyro_pointer_motion_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .move   (move_ch),
    .cfg    (cfg_ch)
  );

  gpm_motion_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample_ch),
    .move       (move_ch),
    .cfg        (cfg_ch),
    .errors     (errors),
    .moves_owed (moves_owed)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(LIMIT_NS);
    $display("gyro_pointer_motion_unit regression: fail");
    $finish;
  end

  // Offers one sample word. Words go out in bursts of random length, with a
  // random gap (sometimes none) before each burst. Ready is looked at on the
  // falling edge, once everything has settled.
  task automatic send_sample(input logic signed [RATE_W-1:0] x,
                             input logic signed [RATE_W-1:0] z);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        sample_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    sample_ch.valid       <= 1'b1;
    sample_ch.gyro_x_rate <= x;
    sample_ch.gyro_z_rate <= z;
    do @(negedge clk); while (!sample_ch.ready);
    @(posedge clk);
    burst_left--;
  endtask

  // Valid is left high so that back-to-back writes need no second assignment
  // on the same edge; the caller lowers it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(negedge clk); while (!cfg_ch.ready);
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [CFG_DATA_W-1:0] db,
                                input logic [CFG_DATA_W-1:0] gain,
                                input logic [CFG_DATA_W-1:0] keep,
                                input bit poke_unused);
    if (poke_unused) write_reg(CFG_IDX_UNUSED, CFG_DATA_W'($urandom));
    write_reg(REG_DEAD_BAND, db);
    write_reg(REG_SENSITIVITY, gain);
    write_reg(REG_SMOOTHING, keep);
    cfg_ch.valid <= 1'b0;
    db_now = int'(db[DEAD_W-1:0]);
  endtask

  // Stops offering, waits for every owed move, then lets a sample that
  // causes no move work its way through the pipeline.
  task automatic settle();
    sample_ch.valid <= 1'b0;
    do @(negedge clk); while (moves_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [RATE_W-1:0] clip_rate(int v);
    if (v > 32767) return RATE_MAX;
    if (v < -32768) return RATE_MIN;
    return RATE_W'(v);
  endfunction

  function automatic logic signed [RATE_W-1:0] extreme_rate();
    case ($urandom_range(0, 5))
      0:       return RATE_MIN;
      1:       return RATE_W'(RATE_MIN + 1);
      2:       return -1;
      3:       return 0;
      4:       return 1;
      default: return RATE_MAX;
    endcase
  endfunction

  // Move sink: runs of steady ready, runs of random ready, short stalls and
  // rare long ones, plus one forced long hold-off once the random traffic
  // is flowing.
  initial begin : move_sink
    int span;
    int mode;
    int cyc;
    bit held;
    bit level;
    cyc  = 0;
    held = 1'b0;
    move_ch.ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 99);
      if (!held && cyc >= HOLD_AT) begin
        held = 1'b1;
        mode = 99;
        span = HOLD_LONG;
      end else if (mode < 85) begin
        span = $urandom_range(1, 20);
      end else if (mode < 99) begin
        span = $urandom_range(1, 10);
      end else begin
        span = $urandom_range(100, 250);
      end
      repeat (span) begin
        @(posedge clk);
        cyc++;
        if (mode < 50) level = 1'b1;
        else if (mode < 85) level = 1'(($urandom_range(0, 1)));
        else level = 1'b0;
        move_ch.ready <= level;
      end
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    int ph;
    int k;
    int sent;
    int kind;
    int run;
    int base_x;
    int base_z;
    int sign_x;
    int sign_z;
    logic [CFG_DATA_W-1:0]     db_data;
    logic [CFG_DATA_W-1:0]     gain;
    logic [CFG_DATA_W-1:0]     keep;
    logic signed [RATE_W-1:0]  x;
    logic signed [RATE_W-1:0]  z;

    sample_ch.valid       <= 1'b0;
    sample_ch.gyro_x_rate <= '0;
    sample_ch.gyro_z_rate <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= REG_DEAD_BAND;
    cfg_ch.data           <= '0;
    rst                   <= 1'b1;
    burst_left = 0;
    db_now     = int'(DEAD_BAND_RST);
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Register defaults: deadzone edge on both sides, slow build-up of a
    // sub-pixel remainder, full-scale rates including the X rate whose
    // negation is 32768.
    send_sample(0, 0);
    send_sample(16, -16);
    send_sample(-17, 17);
    send_sample(-17, 17);
    send_sample(-17, 17);
    send_sample(RATE_MAX, RATE_MIN);
    send_sample(RATE_MIN, RATE_MAX);
    send_sample(-3000, 2500);

    // Full gain and no smoothing: moves far past the limit and the
    // accumulators run into saturation.
    settle();
    apply_settings(16'd0, 16'hFFFF, 16'd0, 1'b0);
    send_sample(RATE_MIN, RATE_MIN);
    send_sample(RATE_MIN, RATE_MIN);
    send_sample(RATE_MAX, RATE_MAX);
    send_sample(1, -1);
    send_sample(0, 0);

    // Widest deadzone, written with the top bit set so it is cut to the
    // register width, and zero gain; an unused index is written too.
    settle();
    apply_settings(16'hFFFF, 16'd0, 16'hFFFF, 1'b1);
    send_sample(RATE_MIN, 5);
    send_sample(100, RATE_MAX);

    // No deadzone and zero gain: the scaled target is zero.
    settle();
    apply_settings(16'd0, 16'd0, 16'hFFFF, 1'b0);
    send_sample(7, -7);

    // Heaviest smoothing under a steady rotation.
    settle();
    apply_settings(16'd200, 16'd40000, 16'hFFFF, 1'b0);
    repeat (4) send_sample(-3000, 3000);

    // Random phases, each under its own settings.
    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      case ($urandom_range(0, 9))
        0:       db_data = 16'd0;
        1:       db_data = 16'hFFFF;
        2:       db_data = CFG_DATA_W'($urandom);
        default: db_data = CFG_DATA_W'($urandom_range(0, 300));
      endcase
      case ($urandom_range(0, 9))
        0:       gain = 16'hFFFF;
        1:       gain = CFG_DATA_W'($urandom_range(20000, 65535));
        default: gain = CFG_DATA_W'($urandom_range(800, 12000));
      endcase
      case ($urandom_range(0, 9))
        0:       keep = 16'd0;
        1:       keep = 16'hFFFF;
        default: keep = CFG_DATA_W'($urandom);
      endcase
      apply_settings(db_data, gain, keep, ph == 1);

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        kind   = $urandom_range(0, 99);
        run    = $urandom_range(3, 15);
        sign_x = $urandom_range(0, 1) ? 1 : -1;
        sign_z = $urandom_range(0, 1) ? 1 : -1;
        if ($urandom_range(0, 6) == 0) begin
          base_x = sign_x * int'($urandom_range(1, 32767));
          base_z = sign_z * int'($urandom_range(1, 32767));
        end else begin
          base_x = sign_x * (db_now + int'($urandom_range(1, 3000)));
          base_z = sign_z * (db_now + int'($urandom_range(1, 3000)));
        end
        // A held rotation sometimes has one axis resting.
        case ($urandom_range(0, 7))
          0:       base_x = 0;
          1:       base_z = 0;
          default: ;
        endcase
        for (k = 0; k < run; k++) begin
          if (kind < 60) begin
            x = clip_rate(base_x + int'($urandom_range(0, 80)) - 40);
            z = clip_rate(base_z + int'($urandom_range(0, 80)) - 40);
          end else if (kind < 75) begin
            x = RATE_W'($urandom);
            z = RATE_W'($urandom);
          end else if (kind < 90) begin
            x = clip_rate(sign_x * (db_now + int'($urandom_range(0, 4)) - 2));
            z = clip_rate(sign_z * (db_now + int'($urandom_range(0, 4)) - 2));
          end else begin
            x = extreme_rate();
            z = extreme_rate();
          end
          send_sample(x, z);
          sent++;
        end
      end
    end

    settle();
    if (errors == 0 && moves_owed == 0) begin
      $display("gyro_pointer_motion_unit regression: pass");
    end else begin
      $display("gyro_pointer_motion_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/gpm_pkg.sv
rtl/core/gpm_if.sv
rtl/core/gpm_ctrl.sv
rtl/core/gpm_datapath.sv
rtl/core/gyro_pointer_motion_unit.sv
dv/gpm_motion_checker.sv
dv/tb_top.sv
